>>> src/mah_pkg.sv
// Shared constants and opcodes of the multichannel ADC histogrammer.
`default_nettype none

package mah_pkg;

  // Size of the histogrammer.
  localparam int CHANNELS    = 64;
  localparam int BINS        = 4096;
  localparam int COUNT_WIDTH = 32;

  // Fixed field widths of the input and result items.
  localparam int OP_W   = 2;
  localparam int WORD_W = 32;
  localparam int IDX_W  = 6;
  localparam int RBIN_W = 13;
  localparam int OUT_W  = 32;

  // Opcodes of an input item.
  localparam logic [OP_W-1:0] OP_WORD = OP_W'(0);
  localparam logic [OP_W-1:0] OP_MAP  = OP_W'(1);
  localparam logic [OP_W-1:0] OP_READ = OP_W'(2);

  // Readout frame format.
  localparam logic [WORD_W-1:0] HEADER_WORD = 32'hFFFF_EA0C;
  localparam int HEIGHT_W   = 16;
  localparam int SKIP_WORDS = 2;

  // Histogram store layout: entry ch * BIN_SLOTS + bin, bin BINS is overflow.
  localparam int BIN_SLOTS   = BINS + 1;
  localparam int STORE_DEPTH = CHANNELS * BIN_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int LOG_W       = (CH_W > IDX_W) ? CH_W : IDX_W;
  localparam int BIN_W       = $clog2(BINS + 1);
  localparam int POS_W       = $clog2(SKIP_WORDS + CHANNELS + 1);

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Result queue.
  localparam int OFIFO_DEPTH = 4;
  localparam int OPTR_W      = $clog2(OFIFO_DEPTH);
  localparam int OCNT_W      = $clog2(OFIFO_DEPTH + 1);

endpackage

`default_nettype wire

>>> src/mah_intf.sv
// Valid/ready channel interfaces for input items and result items.
`default_nettype none

interface mah_in_if;
  import mah_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [WORD_W-1:0] word;
  logic [IDX_W-1:0]  map_source;
  logic [IDX_W-1:0]  map_target;
  logic [IDX_W-1:0]  read_channel;
  logic [RBIN_W-1:0] read_bin;

  modport source (output valid, op, word, map_source, map_target, read_channel, read_bin,
                  input ready);
  modport sink   (input valid, op, word, map_source, map_target, read_channel, read_bin,
                  output ready);
endinterface

interface mah_out_if;
  import mah_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] bin_count;

  modport source (output valid, bin_count, input ready);
  modport sink   (input valid, bin_count, output ready);
endinterface

`default_nettype wire

>>> src/mah_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module mah_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/multichannel_adc_histogrammer.sv
// Multichannel pulse-height histogrammer: frame parser, channel map and histogram store.
// Throughput is one item per cycle while ready is high, in any mix of words, map writes, bin reads.
// A bin read passes the stage 1 and stage 2 registers into the result queue; the queue holds
// it until the sink takes it. A bin increment is a read-modify-write through the store's
// one read and one write port, three pipeline steps with forwarding of the last write.
// After reset the store is swept to zero, one entry a cycle, with ready low; the
// channel map is back to identity and the frame parser idle at once.
`default_nettype none

module multichannel_adc_histogrammer (
  input wire logic clk,
  input wire logic rst,
  mah_in_if.sink   items,
  mah_out_if.source results
);
  import mah_pkg::*;

  // ---------------------------------------------------------------------------
  // Stage 0: input transfer, frame parser and channel map access.
  // ---------------------------------------------------------------------------

  // Store clearing sweep after reset.
  logic              clr_active;
  logic [ADDR_W-1:0] clr_addr;

  // Frame position: zero when idle, then the skip words, then one data word per channel.
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;

  // Map entries that were written since reset; the others read as identity.
  logic [CHANNELS-1:0] map_valid;

  logic in_xfer;
  logic word_xfer;
  logic map_xfer;
  logic read_xfer;
  logic data_word;

  logic [CH_W-1:0]     rd_src;
  logic [HEIGHT_W-1:0] height;
  logic [BIN_W-1:0]    height_bin;

  logic            map_we;
  logic [IDX_W-1:0] map_rdata;

  // Pipeline stage 1 registers.
  logic              s1_inc;
  logic              s1_rd;
  logic              s1_map_vld;
  logic [CH_W-1:0]   s1_src;
  logic [BIN_W-1:0]  s1_bin;
  logic [IDX_W-1:0]  s1_rd_ch;
  logic [RBIN_W-1:0] s1_rd_bin;

  // Pipeline stage 2 registers.
  logic              s2_inc;
  logic              s2_rd;
  logic              s2_rd_ok;
  logic [ADDR_W-1:0] s2_addr;

  // Last write to the store, forwarded to a read of the same entry.
  logic                   fwd_valid;
  logic [ADDR_W-1:0]      fwd_addr;
  logic [COUNT_WIDTH-1:0] fwd_data;

  // Result queue.
  logic [OUT_W-1:0]  ofifo [OFIFO_DEPTH];
  logic [OPTR_W-1:0] owr_ptr;
  logic [OPTR_W-1:0] ord_ptr;
  logic [OCNT_W-1:0] ocount;
  logic              opush;
  logic              opop;
  logic [OCNT_W:0]   committed;

  // A new item is taken only if the queue has room for every read still in flight.
  assign committed = (OCNT_W + 1)'(ocount) + (OCNT_W + 1)'(s1_rd) + (OCNT_W + 1)'(s2_rd);
  assign items.ready = !clr_active && (committed < (OCNT_W + 1)'(OFIFO_DEPTH));

  assign in_xfer   = items.valid && items.ready;
  assign word_xfer = in_xfer && (items.op == OP_WORD);
  assign map_xfer  = in_xfer && (items.op == OP_MAP);
  assign read_xfer = in_xfer && (items.op == OP_READ);

  // Data words start after the header and the two skipped words.
  assign data_word = word_xfer && (pos > POS_W'(SKIP_WORDS));
  assign rd_src    = CH_W'(pos - POS_W'(SKIP_WORDS + 1));

  always_comb begin
    pos_next = pos;
    if (word_xfer) begin
      if (pos == '0) begin
        if (items.word == HEADER_WORD) begin
          pos_next = POS_W'(1);
        end
      end else if (pos >= POS_W'(SKIP_WORDS + CHANNELS)) begin
        pos_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  // Pulse heights of BINS or more land in the overflow bin.
  assign height     = items.word[HEIGHT_W-1:0];
  assign height_bin = (32'(height) >= 32'(BINS)) ? BIN_W'(BINS) : BIN_W'(height);

  // Map writes beyond the channel count are dropped.
  assign map_we = map_xfer && (32'(items.map_source) < 32'(CHANNELS));

  mah_ram #(
    .WIDTH (IDX_W),
    .DEPTH (CHANNELS)
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (CH_W'(items.map_source)),
    .wdata (items.map_target),
    .raddr (rd_src),
    .rdata (map_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      map_valid <= '0;
      s1_inc    <= 1'b0;
      s1_rd     <= 1'b0;
    end else begin
      pos    <= pos_next;
      s1_inc <= data_word;
      s1_rd  <= read_xfer;
      if (map_we) begin
        map_valid[CH_W'(items.map_source)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_map_vld <= map_valid[rd_src];
    s1_src     <= rd_src;
    s1_bin     <= height_bin;
    s1_rd_ch   <= items.read_channel;
    s1_rd_bin  <= items.read_bin;
  end

  // ---------------------------------------------------------------------------
  // Stage 1: logical channel and store address; the store read is issued here.
  // ---------------------------------------------------------------------------

  logic [LOG_W-1:0]  logical;
  logic              hit_ok;
  logic              rd_ok;
  logic [ADDR_W-1:0] addr;

  assign logical = s1_map_vld ? LOG_W'(map_rdata) : LOG_W'(s1_src);
  assign hit_ok  = 32'(logical) < 32'(CHANNELS);
  assign rd_ok   = (32'(s1_rd_ch) < 32'(CHANNELS)) && (32'(s1_rd_bin) <= 32'(BINS));

  always_comb begin
    if (s1_rd) begin
      addr = ADDR_W'(s1_rd_ch) * ADDR_W'(BIN_SLOTS) + ADDR_W'(s1_rd_bin);
    end else begin
      addr = ADDR_W'(logical) * ADDR_W'(BIN_SLOTS) + ADDR_W'(s1_bin);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_inc <= 1'b0;
      s2_rd  <= 1'b0;
    end else begin
      s2_inc <= s1_inc && hit_ok;
      s2_rd  <= s1_rd;
    end
  end

  always_ff @(posedge clk) begin
    s2_addr  <= addr;
    s2_rd_ok <= rd_ok;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: count update and write back, or result into the queue.
  // ---------------------------------------------------------------------------

  logic [COUNT_WIDTH-1:0] hist_rdata;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] inc_val;
  logic [OUT_W-1:0]       rd_val;
  logic                   hist_we;
  logic [ADDR_W-1:0]      hist_waddr;
  logic [COUNT_WIDTH-1:0] hist_wdata;

  // The read and the previous item's write can meet at one clock edge, so the
  // last written value takes precedence over the store's output.
  assign cur     = (fwd_valid && (fwd_addr == s2_addr)) ? fwd_data : hist_rdata;
  assign inc_val = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);

  // Out-of-range reads report zero; wide counters are reported clipped to the result width.
  always_comb begin
    if (!s2_rd_ok) begin
      rd_val = '0;
    end else if ((COUNT_WIDTH > OUT_W) && ((64'(cur) >> OUT_W) != '0)) begin
      rd_val = '1;
    end else begin
      rd_val = OUT_W'(cur);
    end
  end

  assign hist_we    = clr_active || s2_inc;
  assign hist_waddr = clr_active ? clr_addr : s2_addr;
  assign hist_wdata = clr_active ? '0 : inc_val;

  mah_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (STORE_DEPTH)
  ) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .raddr (addr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
      fwd_valid  <= 1'b0;
    end else begin
      if (clr_active) begin
        clr_addr <= clr_addr + ADDR_W'(1);
        if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
          clr_active <= 1'b0;
        end
      end
      if (s2_inc) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_inc) begin
      fwd_addr <= s2_addr;
      fwd_data <= inc_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue; its head drives the result channel.
  // ---------------------------------------------------------------------------

  assign opush = s2_rd;
  assign opop  = results.valid && results.ready;

  assign results.valid     = ocount != '0;
  assign results.bin_count = ofifo[ord_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      owr_ptr <= '0;
      ord_ptr <= '0;
      ocount  <= '0;
    end else begin
      if (opush) begin
        owr_ptr <= owr_ptr + OPTR_W'(1);
      end
      if (opop) begin
        ord_ptr <= ord_ptr + OPTR_W'(1);
      end
      ocount <= ocount + OCNT_W'(opush) - OCNT_W'(opop);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) begin
      ofifo[owr_ptr] <= rd_val;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // No item is taken while the store is being cleared.
  assert property (@(posedge clk) disable iff (rst) clr_active |-> !items.ready)
    else $error("item taken during the clearing sweep");

  // The clearing sweep and a count update never share the write port.
  assert property (@(posedge clk) disable iff (rst) !(clr_active && (s2_inc || s2_rd)))
    else $error("store pipeline active during the clearing sweep");

  // The result queue never overflows.
  assert property (@(posedge clk) disable iff (rst) ocount <= OCNT_W'(OFIFO_DEPTH))
    else $error("result queue overflow");

  // A bin read passes the stage 1 and stage 2 registers and then reaches the queue.
  assert property (@(posedge clk) disable iff (rst) read_xfer |=> ##1 opush)
    else $error("bin read result lost in the pipeline");

  // The frame parser stays within the frame length.
  assert property (@(posedge clk) disable iff (rst) pos <= POS_W'(SKIP_WORDS + CHANNELS))
    else $error("frame position out of range");

endmodule

`default_nettype wire

>>> dv/multichannel_adc_histogrammer_checker.sv
// Scoreboard for the histogrammer: watches both channels, predicts every bin count, compares.
module multichannel_adc_histogrammer_checker (
  input  logic clk,
  input  logic rst,
  mah_in_if    items,
  mah_out_if   results,
  output int   failures,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mah_pkg::*;

  typedef struct {
    logic [OUT_W-1:0]  count;
    logic [IDX_W-1:0]  channel;
    logic [RBIN_W-1:0] bin_sel;
  } count_read_t;

  logic [COUNT_WIDTH-1:0] hist_count [STORE_DEPTH];
  logic [IDX_W-1:0]       chan_route [CHANNELS];
  int unsigned            frame_pos = 0;
  count_read_t            pending_counts [$];
  int                     miss_count = 0;

  function automatic void note_miss(string msg);
    miss_count++;
    if (miss_count <= 10) begin
      $display("%0t ns: bin count mismatch: %s", $time, msg);
    end
  endfunction

  // One pulse height for one readout channel lands in its logical channel.
  function automatic void bump_bin(int unsigned readout, logic [HEIGHT_W-1:0] height);
    int unsigned logical;
    int unsigned bin_idx;
    int unsigned slot;
    if (readout >= CHANNELS) return;
    logical = 32'(chan_route[readout]);
    if (logical >= CHANNELS) return;
    bin_idx = (height >= BINS) ? BINS : 32'(height);
    slot = logical * BIN_SLOTS + bin_idx;
    if (hist_count[slot] != COUNT_MAX) hist_count[slot] = hist_count[slot] + 1'b1;
  endfunction

  // Frame parser: header, two skipped words, then one word per readout channel.
  function automatic void scan_word(logic [WORD_W-1:0] w);
    if (frame_pos == 0) begin
      if (w == HEADER_WORD) frame_pos = 1;
      return;
    end
    if (frame_pos > SKIP_WORDS) bump_bin(frame_pos - SKIP_WORDS - 1, w[HEIGHT_W-1:0]);
    if (frame_pos >= SKIP_WORDS + CHANNELS) frame_pos = 0;
    else frame_pos++;
  endfunction

  function automatic logic [OUT_W-1:0] lookup_count(int unsigned ch, int unsigned b);
    logic [63:0] v;
    v = '0;
    if (ch < CHANNELS && b <= BINS) v = 64'(hist_count[ch * BIN_SLOTS + b]);
    if (v > 64'hFFFF_FFFF) v = 64'hFFFF_FFFF;
    return v[OUT_W-1:0];
  endfunction

  function automatic void absorb_item();
    count_read_t rd;
    case (items.op)
      OP_WORD: begin
        scan_word(items.word);
      end
      OP_MAP: begin
        if (items.map_source < CHANNELS) chan_route[items.map_source] = items.map_target;
      end
      OP_READ: begin
        rd.channel = items.read_channel;
        rd.bin_sel = items.read_bin;
        rd.count   = lookup_count(32'(items.read_channel), 32'(items.read_bin));
        pending_counts.push_back(rd);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void check_count(logic [OUT_W-1:0] got);
    count_read_t want;
    if (pending_counts.size() == 0) begin
      note_miss($sformatf("got %0d with no read waiting", got));
      return;
    end
    want = pending_counts.pop_front();
    if (got !== want.count) begin
      note_miss($sformatf("channel %0d bin %0d: expected %0d, got %0d",
                          want.channel, want.bin_sel, want.count, got));
    end
  endfunction

  // Results are checked before items of the same edge, so a read can never be
  // answered by a result in its own transfer cycle.
  always @(posedge clk) begin
    if (rst) begin
      foreach (hist_count[i]) hist_count[i] = '0;
      foreach (chan_route[i]) chan_route[i] = IDX_W'(i);
      frame_pos = 0;
      pending_counts.delete();
    end else begin
      if (results.valid === 1'b1 && results.ready === 1'b1) check_count(results.bin_count);
      if (items.valid === 1'b1 && items.ready === 1'b1) absorb_item();
    end
    failures    <= miss_count;
    outstanding <= pending_counts.size();
  end

endmodule

>>> dv/multichannel_adc_histogrammer_tb.sv
// Top of the histogrammer testbench: clock, reset, stimulus, result pacing and the verdict.
module multichannel_adc_histogrammer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mah_pkg::*;

  // Transfers that the block acts on (frame words, map writes, bin reads).
  localparam int ITEM_TARGET = 1400;
  // The guard time covers the store sweep after reset and the whole run, even with
  // every stall at its worst.
  localparam int GUARD_NS = 2_000_000;
  localparam int POOL_N = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mah_in_if  items_ch();
  mah_out_if results_ch();

  int failures;
  int outstanding;
  int sent = 0;
  int unsigned send_gap_pct = 33;
  int unsigned take_gap_pct = 49;

  // A handful of pulse heights that frames use again and again, so that bin reads
  // land on counts well above zero.
  logic [HEIGHT_W-1:0] height_pool [POOL_N];

  multichannel_adc_histogrammer DUT (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  multichannel_adc_histogrammer_checker watch (
    .clk         (clk),
    .rst         (rst),
    .items       (items_ch),
    .results     (results_ch),
    .failures    (failures),
    .outstanding (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #GUARD_NS;
    $display("multichannel_adc_histogrammer_tb failed");
    $finish;
  end

  // The result sink stalls at random in the first two thirds of the run and takes
  // every result at once in the last third.
  always @(posedge clk) begin
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= take_gap_pct);
    end
  end

  // One transfer on the item channel. Valid stays high from one item to the next
  // unless a random gap comes between them; the loop leaves at the edge where the
  // block took the item.
  task automatic offer_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] w,
                            logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst,
                            logic [IDX_W-1:0] ch, logic [RBIN_W-1:0] rb, bit acted);
    if (sent < ITEM_TARGET / 3) begin
      send_gap_pct = 33;
      take_gap_pct = 49;
    end else if (sent < 2 * ITEM_TARGET / 3) begin
      send_gap_pct = 49;
      take_gap_pct = 33;
    end else begin
      send_gap_pct = 0;
      take_gap_pct = 0;
    end
    while ($urandom_range(99) < send_gap_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid        <= 1'b1;
    items_ch.op           <= op;
    items_ch.word         <= w;
    items_ch.map_source   <= src;
    items_ch.map_target   <= dst;
    items_ch.read_channel <= ch;
    items_ch.read_bin     <= rb;
    do @(posedge clk); while (items_ch.ready !== 1'b1);
    if (acted) sent++;
  endtask

  // The fields that an op does not use carry random values.
  task automatic offer_word(logic [WORD_W-1:0] w, bit acted);
    offer_item(OP_WORD, w, IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)),
               IDX_W'($urandom_range(63)), RBIN_W'($urandom_range(8191)), acted);
  endtask

  task automatic offer_map(logic [IDX_W-1:0] src, logic [IDX_W-1:0] dst);
    offer_item(OP_MAP, $urandom, src, dst, IDX_W'($urandom_range(63)),
               RBIN_W'($urandom_range(8191)), 1'b1);
  endtask

  task automatic offer_read(logic [IDX_W-1:0] ch, logic [RBIN_W-1:0] rb);
    offer_item(OP_READ, $urandom, IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)),
               ch, rb, 1'b1);
  endtask

  // The spare opcode must be swallowed without a result.
  task automatic offer_spare_op();
    offer_item(~OP_WORD, $urandom, IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)),
               IDX_W'($urandom_range(63)), RBIN_W'($urandom_range(8191)), 1'b0);
  endtask

  // Bin reads mostly aim at bins that frames fill; the rest cover the whole field,
  // out-of-range bins above the overflow bin included.
  function automatic logic [RBIN_W-1:0] pick_bin();
    int unsigned roll;
    logic [HEIGHT_W-1:0] h;
    roll = $urandom_range(99);
    h = height_pool[$urandom_range(POOL_N - 1)];
    if (roll < 70) return (h >= BINS) ? RBIN_W'(BINS) : RBIN_W'(h);
    if (roll < 80) return RBIN_W'(BINS);
    return RBIN_W'($urandom_range(8191));
  endfunction

  // A map write or a bin read slipped in between the words of a frame or between frames.
  task automatic side_op();
    if ($urandom_range(99) < 70) offer_read(IDX_W'($urandom_range(63)), pick_bin());
    else offer_map(IDX_W'($urandom_range(63)), IDX_W'($urandom_range(63)));
  endtask

  // A well-formed frame with random content. mix_pct is the chance of interleaving
  // other ops in front of each word. Skip words are sometimes the header itself, and
  // data words are sometimes the header too, which must count as a plain height.
  task automatic send_frame(int unsigned mix_pct);
    int unsigned roll;
    logic [WORD_W-1:0] w;
    offer_word(HEADER_WORD, 1'b1);
    for (int pos = 1; pos <= SKIP_WORDS + CHANNELS; pos++) begin
      while ($urandom_range(99) < mix_pct) side_op();
      roll = $urandom_range(99);
      w = $urandom;
      if (pos <= SKIP_WORDS) begin
        if (roll < 10) w = HEADER_WORD;
      end else if (roll < 60) begin
        w[HEIGHT_W-1:0] = height_pool[$urandom_range(POOL_N - 1)];
      end else if (roll < 70) begin
        w = HEADER_WORD;
      end
      offer_word(w, 1'b1);
    end
  endtask

  // Traffic between frames: reads, map writes, stray words that the parser must
  // ignore outside a frame, and the spare opcode.
  task automatic chatter();
    int unsigned roll;
    logic [WORD_W-1:0] w;
    roll = $urandom_range(99);
    if (roll < 60) begin
      side_op();
    end else if (roll < 85) begin
      w = $urandom;
      if (w == HEADER_WORD) w = ~w;
      offer_word(w, 1'b0);
    end else begin
      offer_spare_op();
    end
  endtask

  initial begin
    logic [WORD_W-1:0] w;

    items_ch.valid        = 1'b0;
    items_ch.op           = OP_WORD;
    items_ch.word         = '0;
    items_ch.map_source   = '0;
    items_ch.map_target   = '0;
    items_ch.read_channel = '0;
    items_ch.read_bin     = '0;

    height_pool[0] = '0;
    height_pool[1] = HEIGHT_W'(BINS - 1);
    height_pool[2] = HEIGHT_W'(BINS);
    height_pool[3] = '1;
    for (int i = 4; i < POOL_N; i++) height_pool[i] = HEIGHT_W'($urandom_range(BINS - 1));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Fresh store: reads of the first and last channel, the overflow
    // bin, and bins beyond the overflow bin must all return zero.
    offer_read(IDX_W'(0), RBIN_W'(0));
    offer_read(IDX_W'(CHANNELS - 1), RBIN_W'(BINS));
    offer_read(IDX_W'(17), 13'h1FFF);
    offer_read(IDX_W'(5), RBIN_W'(BINS + 1));
    offer_spare_op();
    // Outside a frame, near-headers and other words change nothing.
    offer_word(HEADER_WORD ^ 32'h1, 1'b0);
    offer_word(32'h0000_0000, 1'b0);
    offer_map(IDX_W'(5), IDX_W'(CHANNELS - 1));
    offer_map(IDX_W'(CHANNELS - 1), IDX_W'(0));

    // One frame with known heights: the first skip word is a header, heights cover
    // zero, the last regular bin, the first overflow height and the full 16 bits,
    // and a map write just before its word redirects readout channel 10 to logical 0.
    offer_word(HEADER_WORD, 1'b1);
    for (int pos = 1; pos <= SKIP_WORDS + CHANNELS; pos++) begin
      case (pos - SKIP_WORDS - 1)
        -2:      w = HEADER_WORD;
        -1:      w = 32'h0000_0000;
        0:       w = 32'hFFFF_0000;
        1:       w = 32'h0000_0FFF;
        2:       w = 32'h0000_1000;
        3:       w = 32'hFFFF_FFFF;
        4:       w = HEADER_WORD;
        5:       w = 32'h0000_0003;
        10:      w = 32'h0000_0007;
        default: w = $urandom;
      endcase
      if (pos - SKIP_WORDS - 1 == 10) offer_map(IDX_W'(10), IDX_W'(0));
      offer_word(w, 1'b1);
    end
    offer_read(IDX_W'(0), RBIN_W'(0));
    offer_read(IDX_W'(0), RBIN_W'(7));
    offer_read(IDX_W'(1), RBIN_W'(BINS - 1));
    offer_read(IDX_W'(2), RBIN_W'(BINS));
    offer_read(IDX_W'(3), RBIN_W'(BINS));
    offer_read(IDX_W'(4), RBIN_W'(BINS));
    offer_read(IDX_W'(CHANNELS - 1), RBIN_W'(3));

    // Random part: mostly whole frames, some with other ops woven in, the rest
    // short bursts of traffic between frames.
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(99) < 70) send_frame($urandom_range(20));
      else repeat ($urandom_range(1, 12)) chatter();
    end
    items_ch.valid <= 1'b0;

    // Drain: wait for every read to be answered, then a little longer so that a
    // stray extra result would still be caught.
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("multichannel_adc_histogrammer_tb passed");
    end else begin
      $display("multichannel_adc_histogrammer_tb failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
src/mah_pkg.sv
src/mah_intf.sv
src/mah_ram.sv
src/multichannel_adc_histogrammer.sv
dv/multichannel_adc_histogrammer_checker.sv
dv/multichannel_adc_histogrammer_tb.sv
